FILE: design/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the density grid blur design.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ASSERT_IMP(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define ASSERT_NXT(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: design/dgbb_pkg.sv
// ----------------------------------------------------------------------------
// dgbb_pkg
// Types and constants shared by the density grid blur modules.
// ----------------------------------------------------------------------------
package dgbb_pkg;

  localparam int MAC_AW   = 32;
  localparam int MAC_BW   = 17;
  localparam int MAC_ACCW = 50;

  localparam logic [MAC_ACCW-1:0] MAC_ROUND = 50'h8000;

  localparam logic [1:0] KIND_CLEAR  = 2'd0;
  localparam logic [1:0] KIND_SPLAT  = 2'd1;
  localparam logic [1:0] KIND_BLUR   = 2'd2;
  localparam logic [1:0] KIND_SAMPLE = 2'd3;

  localparam logic STAT_OK        = 1'b0;
  localparam logic STAT_BAD_WIDTH = 1'b1;

  typedef struct packed {
    logic en;
    logic load;
  } mac_ctl_t;

  typedef struct packed {
    logic start;
    logic busy;
    logic done;
  } div_stat_t;

endpackage

FILE: design/dgbb_mac.sv
// ----------------------------------------------------------------------------
// dgbb_mac
// Shared multiply-accumulate unit: when en is set, acc = (load ? round : acc) + a * b.
// ----------------------------------------------------------------------------
module dgbb_mac import dgbb_pkg::*; (
  input  logic                clk,
  input  mac_ctl_t            ctl,
  input  logic [MAC_AW-1:0]   op_a,
  input  logic [MAC_BW-1:0]   op_b,
  output logic [MAC_ACCW-1:0] acc
);

  logic [MAC_ACCW-1:0] acc_r;
  logic [MAC_ACCW-1:0] acc_nxt;
  logic [MAC_ACCW-1:0] prod;

  assign prod = MAC_ACCW'(op_a) * MAC_ACCW'(op_b);

  always_comb begin
    acc_nxt = acc_r;
    if (ctl.en) begin
      acc_nxt = (ctl.load ? MAC_ROUND : acc_r) + prod;
    end
  end

  always_ff @(posedge clk) begin
    acc_r <= acc_nxt;
  end

  assign acc = acc_r;

endmodule

FILE: design/dgbb_div.sv
// ----------------------------------------------------------------------------
// dgbb_div
// Radix-2 restoring divider, one quotient bit per cycle, 32 quotient bits.
// ----------------------------------------------------------------------------
module dgbb_div import dgbb_pkg::*; #(
  parameter int DW = 44
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  input  logic [DW-1:0] dividend,
  input  logic [15:0]   divisor,
  output logic [31:0]   quot,
  output div_stat_t     stat
);

  logic [15:0] rem_r, rem_nxt;
  logic [31:0] lo_r, lo_nxt;
  logic [15:0] dsr_r, dsr_nxt;
  logic [4:0]  cnt_r, cnt_nxt;
  logic        busy_r, busy_nxt;
  logic        done_r, done_nxt;
  logic [16:0] trial;
  logic [16:0] diff;
  logic        ge;

  assign trial = {rem_r, lo_r[31]};
  assign ge    = trial >= {1'b0, dsr_r};
  assign diff  = trial - {1'b0, dsr_r};

  always_comb begin
    rem_nxt  = rem_r;
    lo_nxt   = lo_r;
    dsr_nxt  = dsr_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (start) begin
      // high part is known to be below the divisor
      rem_nxt  = 16'(dividend[DW-1:32]);
      lo_nxt   = dividend[31:0];
      dsr_nxt  = divisor;
      cnt_nxt  = '0;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      rem_nxt = ge ? diff[15:0] : trial[15:0];
      lo_nxt  = {lo_r[30:0], ge};
      cnt_nxt = cnt_r + 5'd1;
      if (cnt_r == 5'd31) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    rem_r <= rem_nxt;
    lo_r  <= lo_nxt;
    dsr_r <= dsr_nxt;
  end

  assign quot       = lo_r;
  assign stat.start = start;
  assign stat.busy  = busy_r;
  assign stat.done  = done_r;

endmodule

FILE: design/density_grid_box_blur_engine.sv
// ----------------------------------------------------------------------------
// density_grid_box_blur_engine
// Density grid with clear, bilinear splat, box blur pass and bilinear sample.
// ----------------------------------------------------------------------------
// Blur: a summed-area pass over every cell, then the box pass per cell (four
//   table reads and the serial divider).
// One item at a time; the next is taken while a result waits in the output reg.
// Reset: a clearing sweep zeroes the grid; no item is taken during it.
module density_grid_box_blur_engine import dgbb_pkg::*; #(
  parameter int GRID_N = 64
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  in_kind,
  input  logic [15:0] in_pos_x,
  input  logic [15:0] in_pos_y,
  input  logic [31:0] in_amount,
  input  logic [7:0]  in_box_width,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [31:0] out_sample_value,
  output logic        out_status
);

  `include "assert_macros.svh"

  localparam int IW    = $clog2(GRID_N);
  localparam int CELLS = GRID_N * GRID_N;
  localparam int CAW   = $clog2(CELLS);
  localparam int PSW   = 32 + 2 * IW;
  localparam logic [15:0]    SPLAT_LIM = 16'((GRID_N - 1) * 256 - 1);
  localparam logic [IW-1:0]  LAST_IDX  = IW'(GRID_N - 1);
  localparam logic [CAW-1:0] LAST_CELL = CAW'(CELLS - 1);

  typedef enum logic [21:0] {
    S_CLR   = 22'h000001,
    S_IDLE  = 22'h000002,
    S_DONE  = 22'h000004,
    S_SP_W  = 22'h000008,
    S_SP_M  = 22'h000010,
    S_SP_WR = 22'h000020,
    S_SM_R0 = 22'h000040,
    S_SM_R1 = 22'h000080,
    S_SM_R2 = 22'h000100,
    S_SM_R3 = 22'h000200,
    S_SM_R4 = 22'h000400,
    S_SM_L0 = 22'h000800,
    S_SM_L1 = 22'h001000,
    S_SM_FN = 22'h002000,
    S_BP_RD = 22'h004000,
    S_BP_WR = 22'h008000,
    S_BB_R0 = 22'h010000,
    S_BB_R1 = 22'h020000,
    S_BB_R2 = 22'h040000,
    S_BB_R3 = 22'h080000,
    S_BB_DV = 22'h100000,
    S_BB_WT = 22'h200000
  } state_t;

  function automatic logic [CAW-1:0] cell_addr(input logic [IW-1:0] row,
                                               input logic [IW-1:0] col);
    return CAW'(row) * CAW'(GRID_N) + CAW'(col);
  endfunction

  state_t          state_r, state_nxt;
  logic [1:0]      k_r, k_nxt;
  logic [IW-1:0]   ix_r, ix_nxt, iy_r, iy_nxt;
  logic [15:0]     fx_r, fx_nxt, fy_r, fy_nxt;
  logic [31:0]     amount_r, amount_nxt;
  logic [16:0]     weight_r, weight_nxt;
  logic [31:0]     a0_r, a0_nxt, a1_r, a1_nxt;
  logic [IW-1:0]   i_r, i_nxt, j_r, j_nxt;
  logic [6:0]      rad_r, rad_nxt;
  logic [15:0]     dsr_r, dsr_nxt;
  logic [PSW-1:0]  rowacc_r, rowacc_nxt;
  logic [PSW-1:0]  s_r, s_nxt;
  logic [CAW-1:0]  clr_r, clr_nxt;
  logic            clr_item_r, clr_item_nxt;
  logic [31:0]     res_value_r, res_value_nxt;
  logic            res_status_r, res_status_nxt;
  logic            out_valid_r, out_valid_nxt;
  logic [31:0]     out_value_r, out_value_nxt;
  logic            out_status_r, out_status_nxt;

  // memories
  logic [31:0]     dens_mem [CELLS];
  logic [PSW-1:0]  pre_mem  [CELLS];
  logic            d_we, p_we;
  logic [CAW-1:0]  d_waddr, d_raddr, p_waddr, p_raddr;
  logic [31:0]     d_wdata, d_rd_r;
  logic [PSW-1:0]  p_wdata, p_rd_r;

  // shared units
  mac_ctl_t              mac_ctl;
  logic [MAC_AW-1:0]     mac_a;
  logic [MAC_BW-1:0]     mac_b;
  logic [MAC_ACCW-1:0]   mac_acc;
  logic                  div_start;
  logic [PSW-1:0]        div_dividend;
  logic [31:0]           div_q;
  div_stat_t             div_stat;

  // item decode
  logic [15:0]     px_cl, py_cl;
  logic [23:0]     tx, ty;
  logic            width_bad;

  // corner and window helpers
  logic [IW-1:0]   c_row, c_col;
  logic [8:0]      wx, wy;
  logic [17:0]     wprod;
  logic [16:0]     gfx, gfy;
  logic [32:0]     contrib;
  logic [33:0]     sat_sum;
  logic [31:0]     sat_val;
  logic [9:0]      i_hi, j_hi, i_lo, j_lo;
  logic [IW-1:0]   i0, i1, j0, j1;
  logic            ni0, nj0;
  logic            last_j, last_i;

  dgbb_mac u_mac (
    .clk  (clk),
    .ctl  (mac_ctl),
    .op_a (mac_a),
    .op_b (mac_b),
    .acc  (mac_acc)
  );

  dgbb_div #(.DW(PSW)) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (dsr_r),
    .quot     (div_q),
    .stat     (div_stat)
  );

  always_ff @(posedge clk) begin
    if (d_we) begin
      dens_mem[d_waddr] <= d_wdata;
    end
    d_rd_r <= dens_mem[d_raddr];
  end

  always_ff @(posedge clk) begin
    if (p_we) begin
      pre_mem[p_waddr] <= p_wdata;
    end
    p_rd_r <= pre_mem[p_raddr];
  end

  assign px_cl     = (in_pos_x > SPLAT_LIM) ? SPLAT_LIM : in_pos_x;
  assign py_cl     = (in_pos_y > SPLAT_LIM) ? SPLAT_LIM : in_pos_y;
  assign tx        = 24'(in_pos_x) * 24'(GRID_N - 1);
  assign ty        = 24'(in_pos_y) * 24'(GRID_N - 1);
  assign width_bad = (in_box_width == 8'd0) || (9'(in_box_width) > 9'(GRID_N));

  assign c_row   = ix_r + IW'(k_r[1]);
  assign c_col   = iy_r + IW'(k_r[0]);
  assign wx      = k_r[1] ? 9'(fx_r[7:0]) : (9'd256 - 9'(fx_r[7:0]));
  assign wy      = k_r[0] ? 9'(fy_r[7:0]) : (9'd256 - 9'(fy_r[7:0]));
  assign wprod   = 18'(wx) * 18'(wy);
  assign gfx     = 17'h10000 - {1'b0, fx_r};
  assign gfy     = 17'h10000 - {1'b0, fy_r};
  assign contrib = mac_acc[48:16];
  assign sat_sum = 34'(d_rd_r) + 34'(contrib);
  assign sat_val = (|sat_sum[33:32]) ? 32'hFFFF_FFFF : sat_sum[31:0];

  assign i_hi = 10'(i_r) + 10'(rad_r);
  assign j_hi = 10'(j_r) + 10'(rad_r);
  assign i1   = (i_hi > 10'(GRID_N - 1)) ? LAST_IDX : i_hi[IW-1:0];
  assign j1   = (j_hi > 10'(GRID_N - 1)) ? LAST_IDX : j_hi[IW-1:0];
  assign ni0  = 10'(i_r) < (10'(rad_r) + 10'd1);
  assign nj0  = 10'(j_r) < (10'(rad_r) + 10'd1);
  assign i_lo = 10'(i_r) - 10'(rad_r) - 10'd1;
  assign j_lo = 10'(j_r) - 10'(rad_r) - 10'd1;
  assign i0   = i_lo[IW-1:0];
  assign j0   = j_lo[IW-1:0];
  assign last_j = j_r == LAST_IDX;
  assign last_i = i_r == LAST_IDX;

  assign div_dividend = s_r + ((ni0 || nj0) ? '0 : p_rd_r) + PSW'(dsr_r >> 1);

  always_comb begin
    state_nxt      = state_r;
    k_nxt          = k_r;
    ix_nxt         = ix_r;
    iy_nxt         = iy_r;
    fx_nxt         = fx_r;
    fy_nxt         = fy_r;
    amount_nxt     = amount_r;
    weight_nxt     = weight_r;
    a0_nxt         = a0_r;
    a1_nxt         = a1_r;
    i_nxt          = i_r;
    j_nxt          = j_r;
    rad_nxt        = rad_r;
    dsr_nxt        = dsr_r;
    rowacc_nxt     = rowacc_r;
    s_nxt          = s_r;
    clr_nxt        = clr_r;
    clr_item_nxt   = clr_item_r;
    res_value_nxt  = res_value_r;
    res_status_nxt = res_status_r;
    out_valid_nxt  = out_valid_r && !out_ready;
    out_value_nxt  = out_value_r;
    out_status_nxt = out_status_r;
    d_we    = 1'b0;
    d_waddr = cell_addr(i_r, j_r);
    d_wdata = div_q;
    d_raddr = cell_addr(c_row, c_col);
    p_we    = 1'b0;
    p_waddr = cell_addr(i_r, j_r);
    p_wdata = ((i_r == '0) ? '0 : p_rd_r) + rowacc_r + PSW'(d_rd_r);
    p_raddr = cell_addr(i1, j1);
    mac_ctl   = '0;
    mac_a     = d_rd_r;
    mac_b     = {1'b0, fy_r};
    div_start = 1'b0;

    case (state_r)
      S_CLR: begin
        d_we    = 1'b1;
        d_waddr = clr_r;
        d_wdata = '0;
        clr_nxt = clr_r + CAW'(1);
        if (clr_r == LAST_CELL) begin
          state_nxt = clr_item_r ? S_DONE : S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_valid) begin
          res_value_nxt  = '0;
          res_status_nxt = STAT_OK;
          k_nxt          = '0;
          case (in_kind)
            KIND_CLEAR: begin
              clr_nxt      = '0;
              clr_item_nxt = 1'b1;
              state_nxt    = S_CLR;
            end
            KIND_SPLAT: begin
              ix_nxt     = px_cl[8 +: IW];
              iy_nxt     = py_cl[8 +: IW];
              fx_nxt     = {8'd0, px_cl[7:0]};
              fy_nxt     = {8'd0, py_cl[7:0]};
              amount_nxt = in_amount;
              state_nxt  = S_SP_W;
            end
            KIND_BLUR: begin
              if (width_bad) begin
                res_status_nxt = STAT_BAD_WIDTH;
                state_nxt      = S_DONE;
              end else begin
                rad_nxt    = 7'((in_box_width - 8'd1) >> 1);
                dsr_nxt    = 16'(in_box_width) * 16'(in_box_width);
                i_nxt      = '0;
                j_nxt      = '0;
                rowacc_nxt = '0;
                state_nxt  = S_BP_RD;
              end
            end
            KIND_SAMPLE: begin
              ix_nxt    = tx[16 +: IW];
              iy_nxt    = ty[16 +: IW];
              fx_nxt    = tx[15:0];
              fy_nxt    = ty[15:0];
              state_nxt = S_SM_R0;
            end
            default: state_nxt = S_IDLE;
          endcase
        end
      end
      S_DONE: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt  = 1'b1;
          out_value_nxt  = res_value_r;
          out_status_nxt = res_status_r;
          clr_item_nxt   = 1'b0;
          state_nxt      = S_IDLE;
        end
      end
      S_SP_W: begin
        weight_nxt = wprod[16:0];
        state_nxt  = S_SP_M;
      end
      S_SP_M: begin
        mac_ctl   = '{en: 1'b1, load: 1'b1};
        mac_a     = amount_r;
        mac_b     = weight_r;
        state_nxt = S_SP_WR;
      end
      S_SP_WR: begin
        d_we    = 1'b1;
        d_waddr = cell_addr(c_row, c_col);
        d_wdata = sat_val;
        k_nxt   = k_r + 2'd1;
        state_nxt = (k_r == 2'd3) ? S_DONE : S_SP_W;
      end
      S_SM_R0: begin
        k_nxt     = 2'd1;
        state_nxt = S_SM_R1;
      end
      S_SM_R1: begin
        mac_ctl   = '{en: 1'b1, load: 1'b1};
        mac_b     = gfy;
        k_nxt     = 2'd2;
        state_nxt = S_SM_R2;
      end
      S_SM_R2: begin
        mac_ctl   = '{en: 1'b1, load: 1'b0};
        mac_b     = {1'b0, fy_r};
        k_nxt     = 2'd3;
        state_nxt = S_SM_R3;
      end
      S_SM_R3: begin
        a0_nxt    = mac_acc[47:16];
        mac_ctl   = '{en: 1'b1, load: 1'b1};
        mac_b     = gfy;
        state_nxt = S_SM_R4;
      end
      S_SM_R4: begin
        mac_ctl   = '{en: 1'b1, load: 1'b0};
        mac_b     = {1'b0, fy_r};
        state_nxt = S_SM_L0;
      end
      S_SM_L0: begin
        a1_nxt    = mac_acc[47:16];
        mac_ctl   = '{en: 1'b1, load: 1'b1};
        mac_a     = a0_r;
        mac_b     = gfx;
        state_nxt = S_SM_L1;
      end
      S_SM_L1: begin
        mac_ctl   = '{en: 1'b1, load: 1'b0};
        mac_a     = a1_r;
        mac_b     = {1'b0, fx_r};
        state_nxt = S_SM_FN;
      end
      S_SM_FN: begin
        res_value_nxt = mac_acc[47:16];
        state_nxt     = S_DONE;
      end
      S_BP_RD: begin
        d_raddr   = cell_addr(i_r, j_r);
        p_raddr   = cell_addr(i_r - IW'(1), j_r);
        state_nxt = S_BP_WR;
      end
      S_BP_WR: begin
        // row running sum plus the table entry one row up
        p_we       = 1'b1;
        rowacc_nxt = last_j ? '0 : (rowacc_r + PSW'(d_rd_r));
        j_nxt      = j_r + IW'(1);
        state_nxt  = S_BP_RD;
        if (last_j) begin
          j_nxt = '0;
          i_nxt = i_r + IW'(1);
          if (last_i) begin
            i_nxt     = '0;
            state_nxt = S_BB_R0;
          end
        end
      end
      S_BB_R0: begin
        p_raddr   = cell_addr(i1, j1);
        state_nxt = S_BB_R1;
      end
      S_BB_R1: begin
        p_raddr   = cell_addr(i0, j1);
        s_nxt     = p_rd_r;
        state_nxt = S_BB_R2;
      end
      S_BB_R2: begin
        p_raddr   = cell_addr(i1, j0);
        s_nxt     = s_r - (ni0 ? '0 : p_rd_r);
        state_nxt = S_BB_R3;
      end
      S_BB_R3: begin
        p_raddr   = cell_addr(i0, j0);
        s_nxt     = s_r - (nj0 ? '0 : p_rd_r);
        state_nxt = S_BB_DV;
      end
      S_BB_DV: begin
        div_start = 1'b1;
        state_nxt = S_BB_WT;
      end
      S_BB_WT: begin
        if (div_stat.done) begin
          d_we      = 1'b1;
          d_waddr   = cell_addr(i_r, j_r);
          d_wdata   = div_q;
          j_nxt     = j_r + IW'(1);
          state_nxt = S_BB_R0;
          if (last_j) begin
            j_nxt = '0;
            i_nxt = i_r + IW'(1);
            if (last_i) begin
              state_nxt = S_DONE;
            end
          end
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_CLR;
      clr_r        <= '0;
      clr_item_r   <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      clr_r        <= clr_nxt;
      clr_item_r   <= clr_item_nxt;
      out_valid_r  <= out_valid_nxt;
    end
    k_r          <= k_nxt;
    ix_r         <= ix_nxt;
    iy_r         <= iy_nxt;
    fx_r         <= fx_nxt;
    fy_r         <= fy_nxt;
    amount_r     <= amount_nxt;
    weight_r     <= weight_nxt;
    a0_r         <= a0_nxt;
    a1_r         <= a1_nxt;
    i_r          <= i_nxt;
    j_r          <= j_nxt;
    rad_r        <= rad_nxt;
    dsr_r        <= dsr_nxt;
    rowacc_r     <= rowacc_nxt;
    s_r          <= s_nxt;
    res_value_r  <= res_value_nxt;
    res_status_r <= res_status_nxt;
    out_value_r  <= out_value_nxt;
    out_status_r <= out_status_nxt;
  end

  assign in_ready         = state_r == S_IDLE;
  assign out_valid        = out_valid_r;
  assign out_sample_value = out_value_r;
  assign out_status       = out_status_r;

  `ASSERT_NXT(a_busy_after_accept, clk, rst_n, in_valid && in_ready, !in_ready, "ready after accept")
  `ASSERT_IMP(a_status_zero_value, clk, rst_n, out_valid && out_status, out_sample_value == 32'd0, "flagged item with value")
  `ASSERT_IMP(a_div_only_in_blur, clk, rst_n, div_stat.busy || div_stat.start, state_r == S_BB_WT || state_r == S_BB_DV, "divider active outside blur")

endmodule
